### hdl/csge_pkg.sv
// Shared types, constants and range tables for the current setpoint gain encoder.
// No dependencies; used by csge_front, csge_queue, csge_div and the top level.
package csge_pkg;

    localparam int unsigned IN_W   = 21;
    localparam int unsigned GAIN_W = 3;
    localparam int unsigned CODE_W = 12;
    localparam int unsigned NUM_W  = 31;
    localparam int unsigned DEN_W  = 21;
    localparam int unsigned RANGES = 10;
    localparam int unsigned SCALE_SHIFT = 10;

    localparam logic [IN_W-1:0] CH_LIMIT      = 21'd320000;
    localparam logic [IN_W-1:0] X2_LIMIT      = 21'd2000;
    localparam logic [IN_W-1:0] DAC_FLOOR_LIM = 21'd1215;
    localparam logic [IN_W-1:0] TOP_LIMIT     = 21'd1600000;

    localparam logic [CODE_W-1:0] DAC_FLOOR = 12'd1215;
    localparam logic [CODE_W-1:0] DAC_OVER  = 12'd1301;
    localparam logic [GAIN_W-1:0] GAIN_OVER = 3'd5;

    // 0.8*4096/1.32*2000 as an exact ratio: 163840000 / (33 * current)
    localparam logic [NUM_W-1:0] X2_NUMER = 31'd163840000;

    // One division request: flags and gain ride along with dividend and divisor.
    typedef struct packed {
        logic              pga_channel;
        logic              dac_gain_double;
        logic [GAIN_W-1:0] pga_gain;
        logic [NUM_W-1:0]  dividend;
        logic [DEN_W-1:0]  divisor;
    } job_t;

    function automatic logic [IN_W-1:0] range_top(input logic [3:0] idx);
        logic [IN_W-1:0] v;
        unique case (idx)
            4'd0:    v = 21'd5000;
            4'd1:    v = 21'd10000;
            4'd2:    v = 21'd20000;
            4'd3:    v = 21'd40000;
            4'd4:    v = 21'd80000;
            4'd5:    v = 21'd100000;
            4'd6:    v = 21'd200000;
            4'd7:    v = 21'd400000;
            4'd8:    v = 21'd800000;
            4'd9:    v = 21'd1600000;
            default: v = 21'd1600000;
        endcase
        return v;
    endfunction

    function automatic logic [GAIN_W-1:0] range_gain(input logic [3:0] idx);
        logic [GAIN_W-1:0] g;
        unique case (idx)
            4'd0:    g = 3'd7;
            4'd1:    g = 3'd6;
            4'd2:    g = 3'd4;
            4'd3:    g = 3'd2;
            4'd4:    g = 3'd1;
            4'd5:    g = 3'd0;
            4'd6:    g = 3'd4;
            4'd7:    g = 3'd2;
            4'd8:    g = 3'd1;
            4'd9:    g = 3'd0;
            default: g = 3'd0;
        endcase
        return g;
    endfunction

endpackage

### hdl/current_setpoint_gain_encoder.sv
// Top level of the current setpoint gain encoder: classifier, request queue, divider pipeline.
// Depends on csge_pkg, csge_front, csge_queue and csge_div.
//
//   channel | handshake              | payload
//   --------+------------------------+---------------------------------------------------
//   in      | in_valid / in_ready    | micro_amp[20:0]
//   out     | out_valid / out_ready  | pga_channel, dac_gain_double, pga_gain[2:0],
//           |                        | dac_code[11:0]
//
// One request per cycle while the output is not stalled; the path is the classifier register,
// the queue write, then 13 divider ranks: a load rank, then 12 that each resolve one quotient bit.
// Reset clears the valid, pointer and count state only; the payload registers are not reset.
// A stalled output freezes the divider pipeline; the four-entry queue and the
// classifier register keep taking requests until they fill.
module current_setpoint_gain_encoder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [csge_pkg::IN_W-1:0]     micro_amp,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          pga_channel,
    output logic                          dac_gain_double,
    output logic [csge_pkg::GAIN_W-1:0]   pga_gain,
    output logic [csge_pkg::CODE_W-1:0]   dac_code
);

    logic           front_valid;
    logic           front_ready;
    csge_pkg::job_t front_job;
    logic           back_valid;
    logic           back_ready;
    csge_pkg::job_t back_job;

    csge_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .micro_amp (micro_amp),
        .job_valid (front_valid),
        .job_ready (front_ready),
        .job       (front_job)
    );

    csge_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_job   (front_job),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_job    (back_job)
    );

    csge_div u_div (
        .clk             (clk),
        .rst_n           (rst_n),
        .job_valid       (back_valid),
        .job_ready       (back_ready),
        .job             (back_job),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .pga_channel     (pga_channel),
        .dac_gain_double (dac_gain_double),
        .pga_gain        (pga_gain),
        .dac_code        (dac_code)
    );

endmodule

### hdl/csge_front.sv
// Front end: accepts a setpoint, classifies its range and builds a division request.
// Depends on csge_pkg.
module csge_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [csge_pkg::IN_W-1:0]     micro_amp,
    output logic                          job_valid,
    input  logic                          job_ready,
    output csge_pkg::job_t                job
);

    logic           valid_reg;
    logic           valid_next;
    csge_pkg::job_t job_reg;
    csge_pkg::job_t job_next;

    logic [csge_pkg::RANGES-1:0] lt;
    logic [csge_pkg::RANGES-1:0] le;
    logic [csge_pkg::IN_W-1:0]   top_sel;
    logic [csge_pkg::GAIN_W-1:0] gain_sel;
    logic [csge_pkg::IN_W+4:0]   x33;
    logic                        accept;

    assign in_ready  = !valid_reg || job_ready;
    assign accept    = in_valid && in_ready;
    assign job_valid = valid_reg;
    assign job       = job_reg;

    always_comb
    begin
        for (int i = 0; i < csge_pkg::RANGES; i++)
        begin
            lt[i] = micro_amp <  csge_pkg::range_top(4'(i));
            le[i] = micro_amp <= csge_pkg::range_top(4'(i));
        end

        // first range bound at or above the current
        top_sel = csge_pkg::TOP_LIMIT;
        for (int i = csge_pkg::RANGES - 1; i >= 0; i--)
        begin
            if (le[i])
            begin
                top_sel = csge_pkg::range_top(4'(i));
            end
        end

        gain_sel = csge_pkg::GAIN_OVER;
        if (micro_amp <= csge_pkg::TOP_LIMIT)
        begin
            gain_sel = csge_pkg::range_gain(4'(csge_pkg::RANGES - 1));
        end
        for (int i = csge_pkg::RANGES - 2; i >= 0; i--)
        begin
            if (lt[i])
            begin
                gain_sel = csge_pkg::range_gain(4'(i));
            end
        end

        x33 = {micro_amp, 5'b0} + (csge_pkg::IN_W + 5)'(micro_amp);

        job_next.pga_channel     = micro_amp < csge_pkg::CH_LIMIT;
        job_next.dac_gain_double = micro_amp < csge_pkg::X2_LIMIT;
        job_next.pga_gain        = gain_sel;

        // fixed codes go through the divider as code / 1
        if (micro_amp < csge_pkg::DAC_FLOOR_LIM)
        begin
            job_next.dividend = csge_pkg::NUM_W'(csge_pkg::DAC_FLOOR);
            job_next.divisor  = csge_pkg::DEN_W'(1);
        end
        else if (micro_amp < csge_pkg::X2_LIMIT)
        begin
            job_next.dividend = csge_pkg::X2_NUMER;
            job_next.divisor  = csge_pkg::DEN_W'(x33);
        end
        else if (micro_amp <= csge_pkg::TOP_LIMIT)
        begin
            job_next.dividend = csge_pkg::NUM_W'({top_sel, csge_pkg::SCALE_SHIFT'(0)});
            job_next.divisor  = csge_pkg::DEN_W'(micro_amp);
        end
        else
        begin
            job_next.dividend = csge_pkg::NUM_W'(csge_pkg::DAC_OVER);
            job_next.divisor  = csge_pkg::DEN_W'(1);
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (job_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg <= job_next;
        end
    end

endmodule

### hdl/csge_queue.sv
// Four-entry request queue between the classifier and the divider pipeline.
// Depends on csge_pkg.
module csge_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  csge_pkg::job_t push_job,
    output logic           pop_valid,
    input  logic           pop_ready,
    output csge_pkg::job_t pop_job
);

    localparam int unsigned DEPTH = 4;
    localparam int unsigned PTR_W = $clog2(DEPTH);

    csge_pkg::job_t    entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [PTR_W:0]    count_reg;
    logic [PTR_W:0]    count_next;
    logic              push;
    logic              pop;

    assign push_ready = count_reg != (PTR_W + 1)'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

### hdl/csge_div.sv
// Back end: restoring divider, one quotient bit per pipeline rank after the load rank, last rank drives the output.
// Depends on csge_pkg.
module csge_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            job_valid,
    output logic                            job_ready,
    input  csge_pkg::job_t                  job,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            pga_channel,
    output logic                            dac_gain_double,
    output logic [csge_pkg::GAIN_W-1:0]     pga_gain,
    output logic [csge_pkg::CODE_W-1:0]     dac_code
);

    localparam int unsigned STAGES = csge_pkg::CODE_W;
    localparam int unsigned WIDE_W = csge_pkg::NUM_W + 1;

    logic                          valid_reg [STAGES+1];
    logic                          ch_reg    [STAGES+1];
    logic                          x2_reg    [STAGES+1];
    logic [csge_pkg::GAIN_W-1:0]   gain_reg  [STAGES+1];
    logic [csge_pkg::NUM_W-1:0]    rem_reg   [STAGES+1];
    logic [csge_pkg::DEN_W-1:0]    den_reg   [STAGES+1];
    logic [csge_pkg::CODE_W-1:0]   quo_reg   [STAGES+1];

    logic [csge_pkg::NUM_W-1:0]    rem_next  [STAGES];
    logic [csge_pkg::CODE_W-1:0]   quo_next  [STAGES];
    logic [WIDE_W-1:0]             shifted   [STAGES];
    logic                          fits      [STAGES];
    logic                          pipe_en;

    assign pipe_en   = !valid_reg[STAGES] || out_ready;
    assign job_ready = pipe_en;

    assign out_valid       = valid_reg[STAGES];
    assign pga_channel     = ch_reg[STAGES];
    assign dac_gain_double = x2_reg[STAGES];
    assign pga_gain        = gain_reg[STAGES];
    assign dac_code        = quo_reg[STAGES];

    always_comb
    begin
        for (int k = 0; k < STAGES; k++)
        begin
            shifted[k]  = {(WIDE_W - csge_pkg::DEN_W)'(0), den_reg[k]} << (STAGES - 1 - k);
            fits[k]     = {1'b0, rem_reg[k]} >= shifted[k];
            rem_next[k] = fits[k] ? rem_reg[k] - csge_pkg::NUM_W'(shifted[k]) : rem_reg[k];
            quo_next[k] = quo_reg[k];
            quo_next[k][STAGES - 1 - k] = fits[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= STAGES; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (pipe_en)
        begin
            valid_reg[0] <= job_valid;
            for (int k = 0; k < STAGES; k++)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            ch_reg[0]   <= job.pga_channel;
            x2_reg[0]   <= job.dac_gain_double;
            gain_reg[0] <= job.pga_gain;
            rem_reg[0]  <= job.dividend;
            den_reg[0]  <= job.divisor;
            quo_reg[0]  <= '0;
            for (int k = 0; k < STAGES; k++)
            begin
                ch_reg[k+1]   <= ch_reg[k];
                x2_reg[k+1]   <= x2_reg[k];
                gain_reg[k+1] <= gain_reg[k];
                rem_reg[k+1]  <= rem_next[k];
                den_reg[k+1]  <= den_reg[k];
                quo_reg[k+1]  <= quo_next[k];
            end
        end
    end

endmodule

### test/tb_top.sv
// Testbench for current_setpoint_gain_encoder: a directed table, checked against typed settings
// or an independent setting predictor, and random setpoints checked against that predictor.
// Depends on csge_pkg and current_setpoint_gain_encoder.
module tb_top;

    import csge_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLD_CYCLES = 80;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned DIR_N = 25;

    typedef struct packed {
        logic              pga_channel;
        logic              dac_gain_double;
        logic [GAIN_W-1:0] pga_gain;
        logic [CODE_W-1:0] dac_code;
    } setting_t;

    typedef struct packed {
        logic [IN_W-1:0] amp;
        logic            typed;
        setting_t        want;
    } dir_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [IN_W-1:0]     micro_amp = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                pga_channel;
    logic                dac_gain_double;
    logic [GAIN_W-1:0]   pga_gain;
    logic [CODE_W-1:0]   dac_code;

    setting_t            offered_setting = '0;
    setting_t            setting_q[$];
    dir_row_t            dir_rows [DIR_N];
    int unsigned         src_idle = 0;
    int unsigned         sink_idle = 0;
    logic                sink_hold = 1'b0;
    bit                  hold_arm = 1'b0;
    int unsigned         errors = 0;
    int unsigned         cycle_cnt = 0;

    current_setpoint_gain_encoder u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .micro_amp       (micro_amp),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .pga_channel     (pga_channel),
        .dac_gain_double (dac_gain_double),
        .pga_gain        (pga_gain),
        .dac_code        (dac_code)
    );

    initial
    begin
        forever
        begin
            #6 clk = ~clk;
        end
    end

    function automatic setting_t predict_setting(input logic [IN_W-1:0] amp);
        setting_t        s;
        longint unsigned a;
        longint unsigned top;
        a = amp;
        s.pga_channel     = (a < 320000);
        s.dac_gain_double = (a < 2000);
        if (a < 5000)          s.pga_gain = 3'd7;
        else if (a < 10000)    s.pga_gain = 3'd6;
        else if (a < 20000)    s.pga_gain = 3'd4;
        else if (a < 40000)    s.pga_gain = 3'd2;
        else if (a < 80000)    s.pga_gain = 3'd1;
        else if (a < 100000)   s.pga_gain = 3'd0;
        else if (a < 200000)   s.pga_gain = 3'd4;
        else if (a < 400000)   s.pga_gain = 3'd2;
        else if (a < 800000)   s.pga_gain = 3'd1;
        else if (a <= 1600000) s.pga_gain = 3'd0;
        else                   s.pga_gain = 3'd5;
        if (a <= 5000)         top = 5000;
        else if (a <= 10000)   top = 10000;
        else if (a <= 20000)   top = 20000;
        else if (a <= 40000)   top = 40000;
        else if (a <= 80000)   top = 80000;
        else if (a <= 100000)  top = 100000;
        else if (a <= 200000)  top = 200000;
        else if (a <= 400000)  top = 400000;
        else if (a <= 800000)  top = 800000;
        else                   top = 1600000;
        if (a < 1215)
            s.dac_code = 12'd1215;
        else if (a < 2000)
            s.dac_code = CODE_W'(64'd163840000 / (64'd33 * a));
        else if (a <= 1600000)
            s.dac_code = CODE_W'((64'd1024 * top) / a);
        else
            s.dac_code = 12'd1301;
        return s;
    endfunction

    function automatic logic [IN_W-1:0] random_setpoint();
        longint unsigned edge_val;
        case ($urandom_range(0, 4))
            0, 4: return IN_W'($urandom_range(0, 2097151));
            1:
            begin
                case ($urandom_range(0, 12))
                    0:  edge_val = 1215;
                    1:  edge_val = 2000;
                    2:  edge_val = 5000;
                    3:  edge_val = 10000;
                    4:  edge_val = 20000;
                    5:  edge_val = 40000;
                    6:  edge_val = 80000;
                    7:  edge_val = 100000;
                    8:  edge_val = 200000;
                    9:  edge_val = 320000;
                    10: edge_val = 400000;
                    11: edge_val = 800000;
                    default: edge_val = 1600000;
                endcase
                return IN_W'(edge_val + $urandom_range(0, 16) - 8);
            end
            2: return IN_W'($urandom_range(0, 2000));
            default: return IN_W'($urandom_range(0, 1600000));
        endcase
    endfunction

    task automatic send_request(input logic [IN_W-1:0] amp, input setting_t want);
        while ($urandom_range(0, 99) < src_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        micro_amp       <= amp;
        offered_setting <= want;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // receiver: random stalls plus one long hold-off
    always @(posedge clk)
    begin
        out_ready <= !sink_hold && ($urandom_range(0, 99) >= sink_idle);
    end

    initial
    begin
        wait (hold_arm);
        @(posedge clk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            setting_q.push_back(offered_setting);
        if (rst_n && out_valid && out_ready)
        begin
            if (setting_q.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, got ch=%0d x2=%0d gain=%0d dac=%0d",
                         $time, pga_channel, dac_gain_double, pga_gain, dac_code);
                errors++;
            end
            else
            begin
                setting_t exp_s;
                exp_s = setting_q.pop_front();
                if (pga_channel !== exp_s.pga_channel)
                begin
                    $display("%0t: pga_channel expected %0d got %0d",
                             $time, exp_s.pga_channel, pga_channel);
                    errors++;
                end
                if (dac_gain_double !== exp_s.dac_gain_double)
                begin
                    $display("%0t: dac_gain_double expected %0d got %0d",
                             $time, exp_s.dac_gain_double, dac_gain_double);
                    errors++;
                end
                if (pga_gain !== exp_s.pga_gain)
                begin
                    $display("%0t: pga_gain expected %0d got %0d",
                             $time, exp_s.pga_gain, pga_gain);
                    errors++;
                end
                if (dac_code !== exp_s.dac_code)
                begin
                    $display("%0t: dac_code expected %0d got %0d",
                             $time, exp_s.dac_code, dac_code);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        logic [IN_W-1:0] amp;
        // zero current, x2 edge, every range bound, channel edge, over-range
        dir_rows = '{
            '{21'd0,       1'b1, '{1'b1, 1'b1, 3'd7, 12'd1215}},
            '{21'd1,       1'b1, '{1'b1, 1'b1, 3'd7, 12'd1215}},
            '{21'd1214,    1'b1, '{1'b1, 1'b1, 3'd7, 12'd1215}},
            '{21'd1215,    1'b1, '{1'b1, 1'b1, 3'd7, 12'd4086}},
            '{21'd1999,    1'b0, '0},
            '{21'd2000,    1'b1, '{1'b1, 1'b0, 3'd7, 12'd2560}},
            '{21'd4999,    1'b0, '0},
            '{21'd5000,    1'b1, '{1'b1, 1'b0, 3'd6, 12'd1024}},
            '{21'd5001,    1'b0, '0},
            '{21'd9999,    1'b0, '0},
            '{21'd10000,   1'b1, '{1'b1, 1'b0, 3'd4, 12'd1024}},
            '{21'd20000,   1'b1, '{1'b1, 1'b0, 3'd2, 12'd1024}},
            '{21'd40000,   1'b1, '{1'b1, 1'b0, 3'd1, 12'd1024}},
            '{21'd80000,   1'b1, '{1'b1, 1'b0, 3'd0, 12'd1024}},
            '{21'd99999,   1'b0, '0},
            '{21'd100000,  1'b1, '{1'b1, 1'b0, 3'd4, 12'd1024}},
            '{21'd200000,  1'b1, '{1'b1, 1'b0, 3'd2, 12'd1024}},
            '{21'd319999,  1'b0, '0},
            '{21'd320000,  1'b1, '{1'b0, 1'b0, 3'd2, 12'd1280}},
            '{21'd400000,  1'b1, '{1'b0, 1'b0, 3'd1, 12'd1024}},
            '{21'd800000,  1'b1, '{1'b0, 1'b0, 3'd0, 12'd1024}},
            '{21'd1048576, 1'b0, '0},
            '{21'd1600000, 1'b1, '{1'b0, 1'b0, 3'd0, 12'd1024}},
            '{21'd1600001, 1'b1, '{1'b0, 1'b0, 3'd5, 12'd1301}},
            '{21'd2097151, 1'b1, '{1'b0, 1'b0, 3'd5, 12'd1301}}
        };
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_N; i++)
            send_request(dir_rows[i].amp,
                         dir_rows[i].typed ? dir_rows[i].want
                                           : predict_setting(dir_rows[i].amp));

        src_idle  = 10;
        sink_idle = 78;
        repeat (384)
        begin
            amp = random_setpoint();
            send_request(amp, predict_setting(amp));
        end

        src_idle  = 78;
        sink_idle = 10;
        repeat (384)
        begin
            amp = random_setpoint();
            send_request(amp, predict_setting(amp));
        end

        src_idle  = 0;
        sink_idle = 0;
        hold_arm  = 1'b1;
        repeat (382)
        begin
            amp = random_setpoint();
            send_request(amp, predict_setting(amp));
        end
        in_valid <= 1'b0;
        @(posedge clk);

        wait (setting_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
